FILE: design/aids_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aids_pkg: shared codes for the array insert/delete/search block
// Command and status encodings carried on the block's channels and used by the block and its checker.
// ----------------------------------------------------------------------------
package aids_pkg;

  // Command codes carried on the request channel
  localparam logic [2:0] CMD_LOAD    = 3'd0;
  localparam logic [2:0] CMD_DISPLAY = 3'd1;
  localparam logic [2:0] CMD_INSERT  = 3'd2;
  localparam logic [2:0] CMD_DELETE  = 3'd3;
  localparam logic [2:0] CMD_SEARCH  = 3'd4;

  // Status codes carried on the response channel
  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_ELEM     = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_BADPOS   = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_EMPTY    = 3'd6;

endpackage
`default_nettype wire

FILE: design/aids_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aids_req_if: request channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface aids_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic               start_new;
  logic [6:0]         position;
  logic signed [31:0] value;

  modport source (output valid, command, start_new, position, value, input ready);
  modport sink   (input valid, command, start_new, position, value, output ready);
endinterface
`default_nettype wire

FILE: design/aids_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aids_rsp_if: response channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface aids_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [6:0]         index;
  logic signed [31:0] element;
  logic               last;

  modport source (output valid, status, index, element, last, input ready);
  modport sink   (input valid, status, index, element, last, output ready);
endinterface
`default_nettype wire

FILE: design/array_insert_delete_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// array_insert_delete_search: ordered array with insert, delete and search
// Holds up to CAPACITY signed words in one RAM plus a length register.
// ----------------------------------------------------------------------------
// One command is worked at a time; the request channel is ready only while
// the block is idle. Load, bad-position, full and empty cases go straight to
// the closing response beat. Display streams one element beat per cycle
// while the response side is not stalling. Search reads one element per
// cycle and stops at the first match. Insert and delete move each element
// behind the position, one per cycle, through the RAM's single read and
// single write port. The RAM is never written and read at the same entry
// in one cycle. Stored values are VALUE_WIDTH bits: inputs are sign-extended
// or wrapped to that width, and displayed elements are sign-extended or cut
// back to 32 bits.
module array_insert_delete_search #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input wire logic  clk,
  input wire logic  rst,
  aids_req_if.sink  req,
  aids_rsp_if.source rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DISP = 7'b0000010,
    S_SRCH = 7'b0000100,
    S_INS  = 7'b0001000,
    S_INSV = 7'b0010000,
    S_DEL  = 7'b0100000,
    S_RESP = 7'b1000000
  } state_t;

  state_t                 state, state_next;
  logic [LW-1:0]          length, length_next;
  logic [LW-1:0]          ptr, ptr_next;
  logic [LW-1:0]          pos, pos_next;
  logic [VALUE_WIDTH-1:0] key, key_next;
  logic [2:0]             resp_status, resp_status_next;
  logic [6:0]             resp_index, resp_index_next;

  logic                   o_valid;
  logic [2:0]             o_status;
  logic [6:0]             o_index;
  logic signed [31:0]     o_element;
  logic                   o_last;

  logic                   req_fire, slot_free, push;
  logic [2:0]             push_status;
  logic [6:0]             push_index;
  logic signed [31:0]     push_element;
  logic                   push_last;

  logic                   we, re;
  logic [AW-1:0]          waddr, raddr;
  logic [VALUE_WIDTH-1:0] wdata, rd_data;

  logic [63:0]            val_wide, rd_wide;
  logic [VALUE_WIDTH-1:0] val_s;
  logic signed [31:0]     rd_elem;
  logic [7:0]             pos8, len8;
  logic [LW-1:0]          ptr_inc, ptr_inc2, ptr_dec2, len_dec, pos_dec, req_pos;

  // Element store
  aids_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // Width conversion between the 32-bit fields and stored words
  assign val_wide = 64'($signed(req.value));
  assign val_s    = val_wide[VALUE_WIDTH-1:0];
  assign rd_wide  = 64'($signed(rd_data));
  assign rd_elem  = $signed(rd_wide[31:0]);

  assign pos8     = {1'b0, req.position};
  assign len8     = 8'(length);
  assign req_pos  = LW'(req.position);
  assign ptr_inc  = ptr + LW'(1);
  assign ptr_inc2 = ptr + LW'(2);
  assign ptr_dec2 = ptr - LW'(2);
  assign len_dec  = length - LW'(1);
  assign pos_dec  = pos - LW'(1);

  assign req_fire  = req.valid && req.ready;
  assign slot_free = !o_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  // Sequencer: decode the command, walk the RAM, post result beats
  always_comb begin
    state_next       = state;
    length_next      = length;
    ptr_next         = ptr;
    pos_next         = pos;
    key_next         = key;
    resp_status_next = resp_status;
    resp_index_next  = resp_index;
    we               = 1'b0;
    waddr            = '0;
    wdata            = val_s;
    re               = 1'b0;
    raddr            = '0;
    push             = 1'b0;
    push_status      = aids_pkg::ST_DONE;
    push_index       = '0;
    push_element     = '0;
    push_last        = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          resp_status_next = aids_pkg::ST_DONE;
          resp_index_next  = '0;
          key_next         = val_s;
          state_next       = S_RESP;
          case (req.command)
            aids_pkg::CMD_LOAD: begin
              if (req.start_new) begin
                we          = 1'b1;
                waddr       = '0;
                length_next = LW'(1);
              end else if (length >= CAP_L) begin
                resp_status_next = aids_pkg::ST_FULL;
              end else begin
                we          = 1'b1;
                waddr       = length[AW-1:0];
                length_next = length + LW'(1);
              end
            end
            aids_pkg::CMD_DISPLAY: begin
              if (length == '0) begin
                resp_status_next = aids_pkg::ST_EMPTY;
              end else begin
                re         = 1'b1;
                raddr      = '0;
                ptr_next   = '0;
                state_next = S_DISP;
              end
            end
            aids_pkg::CMD_INSERT: begin
              if (pos8 == 8'd0 || pos8 > len8 + 8'd1) begin
                resp_status_next = aids_pkg::ST_BADPOS;
              end else if (length >= CAP_L) begin
                resp_status_next = aids_pkg::ST_FULL;
              end else if (pos8 == len8 + 8'd1) begin
                // append at the tail, nothing to shift
                we          = 1'b1;
                waddr       = length[AW-1:0];
                length_next = length + LW'(1);
              end else begin
                re         = 1'b1;
                raddr      = len_dec[AW-1:0];
                ptr_next   = length;
                pos_next   = req_pos;
                state_next = S_INS;
              end
            end
            aids_pkg::CMD_DELETE: begin
              if (pos8 == 8'd0 || pos8 > len8) begin
                resp_status_next = aids_pkg::ST_BADPOS;
              end else if (pos8 == len8) begin
                // drop the tail element, nothing to shift
                length_next = len_dec;
              end else begin
                re         = 1'b1;
                raddr      = req_pos[AW-1:0];
                ptr_next   = req_pos - LW'(1);
                state_next = S_DEL;
              end
            end
            aids_pkg::CMD_SEARCH: begin
              if (length == '0) begin
                resp_status_next = aids_pkg::ST_NOTFOUND;
              end else begin
                re         = 1'b1;
                raddr      = '0;
                ptr_next   = '0;
                state_next = S_SRCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Stream elements; read the next one only when this beat moves
      S_DISP: begin
        if (slot_free) begin
          push         = 1'b1;
          push_status  = aids_pkg::ST_ELEM;
          push_index   = 7'(ptr_inc);
          push_element = rd_elem;
          push_last    = (ptr_inc == length);
          if (ptr_inc == length) begin
            state_next = S_IDLE;
          end else begin
            re       = 1'b1;
            raddr    = ptr_inc[AW-1:0];
            ptr_next = ptr_inc;
          end
        end
      end

      // Compare one element per cycle, stop at the first match
      S_SRCH: begin
        if (rd_data == key) begin
          resp_status_next = aids_pkg::ST_FOUND;
          resp_index_next  = 7'(ptr_inc);
          state_next       = S_RESP;
        end else if (ptr_inc == length) begin
          resp_status_next = aids_pkg::ST_NOTFOUND;
          state_next       = S_RESP;
        end else begin
          re       = 1'b1;
          raddr    = ptr_inc[AW-1:0];
          ptr_next = ptr_inc;
        end
      end

      // Shift up: write entry ptr from entry ptr-1, read ptr-2 meanwhile
      S_INS: begin
        we    = 1'b1;
        waddr = ptr[AW-1:0];
        wdata = rd_data;
        if (ptr == pos) begin
          state_next = S_INSV;
        end else begin
          re       = 1'b1;
          raddr    = ptr_dec2[AW-1:0];
          ptr_next = ptr - LW'(1);
        end
      end

      // Drop the new value into the opened slot
      S_INSV: begin
        we          = 1'b1;
        waddr       = pos_dec[AW-1:0];
        wdata       = key;
        length_next = length + LW'(1);
        state_next  = S_RESP;
      end

      // Shift down: write entry ptr from entry ptr+1, read ptr+2 meanwhile
      S_DEL: begin
        we    = 1'b1;
        waddr = ptr[AW-1:0];
        wdata = rd_data;
        if (ptr_inc2 == length) begin
          length_next = len_dec;
          state_next  = S_RESP;
        end else begin
          re       = 1'b1;
          raddr    = ptr_inc2[AW-1:0];
          ptr_next = ptr_inc;
        end
      end

      // Post the single closing beat
      S_RESP: begin
        if (slot_free) begin
          push        = 1'b1;
          push_status = resp_status;
          push_index  = resp_index;
          push_last   = 1'b1;
          state_next  = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      length  <= '0;
      o_valid <= 1'b0;
    end else begin
      state  <= state_next;
      length <= length_next;
      if (push) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // Walk registers and the output beat
  always_ff @(posedge clk) begin
    ptr         <= ptr_next;
    pos         <= pos_next;
    key         <= key_next;
    resp_status <= resp_status_next;
    resp_index  <= resp_index_next;
    if (push) begin
      o_status  <= push_status;
      o_index   <= push_index;
      o_element <= push_element;
      o_last    <= push_last;
    end
  end

  assign rsp.valid   = o_valid;
  assign rsp.status  = o_status;
  assign rsp.index   = o_index;
  assign rsp.element = o_element;
  assign rsp.last    = o_last;

endmodule
`default_nettype wire

FILE: design/aids_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aids_ram: simple dual-port element store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module aids_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; read data holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: design/aids_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aids_chk: port checker for the array insert/delete/search block
// Watches the request and response channels and flags illegal behavior.
// ----------------------------------------------------------------------------
module aids_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [2:0]  rsp_status,
  input wire logic [6:0]  rsp_index,
  input wire logic [31:0] rsp_element,
  input wire logic        rsp_last
);

  // Hold a stalled response beat
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response beat dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_index)
      && $stable(rsp_element) && $stable(rsp_last))
    else $error("stalled response beat changed");

  // Take one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while a command is in flight");

  // Only displayed elements continue a burst
  a_burst: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> rsp_status == aids_pkg::ST_ELEM)
    else $error("non-element beat without last");

  // Index and element only where the status gives them meaning
  a_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |->
      ((rsp_status == aids_pkg::ST_ELEM || rsp_status == aids_pkg::ST_FOUND)
        ? (rsp_index != 7'd0) : (rsp_index == 7'd0))
      && (rsp_status == aids_pkg::ST_ELEM || rsp_element == 32'd0))
    else $error("index or element set on the wrong status");

endmodule

bind array_insert_delete_search aids_chk u_aids_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_status  (rsp.status),
  .rsp_index   (rsp.index),
  .rsp_element (rsp.element),
  .rsp_last    (rsp.last)
);
`default_nettype wire

FILE: verif/array_insert_delete_search_tb.sv
// ----------------------------------------------------------------------------
// array_insert_delete_search_tb: self-checking bench for the ordered array
// Drives load, display, insert, delete, search and spare command beats with
// random gaps on both channels. A scoreboard keeps its own copy of the array
// and its length, and checks every response beat field by field, in order.
// ----------------------------------------------------------------------------
module array_insert_delete_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY     = 64;
  localparam int RANDOM_ITEMS = 125;
  localparam int FILL_AT      = 90;
  localparam int HOLD_AT      = 40;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int LIMIT_NS     = 8_000_000;
  localparam int MAX_PRINTS   = 40;

  // Codes the block does not define; they must act as a no-op
  localparam logic [2:0] CMD_SPARE5 = 3'd5;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  index;
    logic [31:0] element;
    logic        last;
  } rsp_beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow array, expected response beats, mismatch count
  // --------------------------------------------------------------------------
  class array_scoreboard;
    logic [31:0] stored [CAPACITY];
    int          fill;
    int          deepest;
    rsp_beat_t   awaited [$];
    int          errors;
    int          beats_checked;
    int          cmd_count [8];

    function new();
      fill          = 0;
      deepest       = 0;
      errors        = 0;
      beats_checked = 0;
      foreach (cmd_count[k]) cmd_count[k] = 0;
    endfunction

    function void add_beat(input logic [2:0] st, input int idx, input logic [31:0] el,
                           input logic fin);
      rsp_beat_t b;
      b.status  = st;
      b.index   = 7'(idx);
      b.element = el;
      b.last    = fin;
      awaited.push_back(b);
    endfunction

    // Update the shadow array for one accepted command and queue its beats
    function void apply_command(input logic [2:0] cmd, input logic start,
                                input logic [6:0] pos, input logic [31:0] val);
      int p;
      int k;
      int hit;
      p   = int'(pos);
      hit = 0;
      cmd_count[cmd]++;
      case (cmd)
        aids_pkg::CMD_LOAD: begin
          if (start) fill = 0;
          if (fill >= CAPACITY) begin
            add_beat(aids_pkg::ST_FULL, 0, '0, 1'b1);
          end else begin
            stored[fill] = val;
            fill++;
            add_beat(aids_pkg::ST_DONE, 0, '0, 1'b1);
          end
        end
        aids_pkg::CMD_DISPLAY: begin
          if (fill == 0) begin
            add_beat(aids_pkg::ST_EMPTY, 0, '0, 1'b1);
          end else begin
            for (k = 0; k < fill; k++)
              add_beat(aids_pkg::ST_ELEM, k + 1, stored[k], k + 1 == fill);
          end
        end
        aids_pkg::CMD_INSERT: begin
          // position check comes ahead of the full check
          if (p == 0 || p > fill + 1) begin
            add_beat(aids_pkg::ST_BADPOS, 0, '0, 1'b1);
          end else if (fill >= CAPACITY) begin
            add_beat(aids_pkg::ST_FULL, 0, '0, 1'b1);
          end else begin
            for (k = fill; k >= p; k--) stored[k] = stored[k - 1];
            stored[p - 1] = val;
            fill++;
            add_beat(aids_pkg::ST_DONE, 0, '0, 1'b1);
          end
        end
        aids_pkg::CMD_DELETE: begin
          if (p == 0 || p > fill) begin
            add_beat(aids_pkg::ST_BADPOS, 0, '0, 1'b1);
          end else begin
            for (k = p - 1; k + 1 < fill; k++) stored[k] = stored[k + 1];
            fill--;
            add_beat(aids_pkg::ST_DONE, 0, '0, 1'b1);
          end
        end
        aids_pkg::CMD_SEARCH: begin
          for (k = 0; k < fill && hit == 0; k++) begin
            if (stored[k] == val) hit = k + 1;
          end
          if (hit != 0) add_beat(aids_pkg::ST_FOUND, hit, '0, 1'b1);
          else          add_beat(aids_pkg::ST_NOTFOUND, 0, '0, 1'b1);
        end
        default: begin
          add_beat(aids_pkg::ST_DONE, 0, '0, 1'b1);
        end
      endcase
      if (fill > deepest) deepest = fill;
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compare one response beat with the oldest expected beat
    task check_result(input logic [2:0] st, input logic [6:0] idx, input logic [31:0] el,
                      input logic fin);
      rsp_beat_t got;
      rsp_beat_t want;
      got.status  = st;
      got.index   = idx;
      got.element = el;
      got.last    = fin;
      beats_checked++;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected beat status=%0d index=%0d element=%0d last=%0d",
                         st, idx, $signed(el), fin));
      end else begin
        want = awaited.pop_front();
        if (got !== want) begin
          report($sformatf("got status=%0d index=%0d element=%0d last=%0d, want %0d %0d %0d %0d",
                           st, idx, $signed(el), fin, want.status, want.index,
                           $signed(want.element), want.last));
        end
      end
    endtask
  endclass

  logic clk;
  logic rst;
  bit   stall_request;
  int   holds_done;

  array_scoreboard sb;

  aids_req_if req_ch ();
  aids_rsp_if rsp_ch ();

  array_insert_delete_search dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #2 clk = ~clk;

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Values weighted toward the extremes and small repeats for search hits
  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3, 4:    return 32'($urandom_range(0, 7)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  // Position outside the valid window, or at 64 or 65, at and just past the capacity
  function automatic logic [6:0] odd_position(input int top);
    case ($urandom_range(0, 3))
      0:       return 7'd0;
      1:       return (top + 1 > 65) ? 7'd65 : 7'(top + 1);
      2:       return 7'd64;
      default: return 7'd65;
    endcase
  endfunction

  // Offer one command beat after an idle gap and hold it until accepted
  task automatic send_cmd(input logic [2:0] cmd, input logic start, input logic [6:0] pos,
                          input logic [31:0] val, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid     <= 1'b1;
    req_ch.command   <= cmd;
    req_ch.start_new <= start;
    req_ch.position  <= pos;
    req_ch.value     <= val;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.apply_command(cmd, start, pos, val);
  endtask

  // Check every response beat taken at a rising edge
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      sb.check_result(rsp_ch.status, rsp_ch.index, rsp_ch.element, rsp_ch.last);
    end
  end

  // Response side: random ready pattern plus one long hold-off on request
  initial begin : drive_ready
    int run;
    int gap;
    rsp_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (stall_request) begin
        @(negedge clk);
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        stall_request = 1'b0;
        holds_done++;
      end
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      @(negedge clk);
      rsp_ch.ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      gap = pick_gap(1'b0);
      if (gap > 0) begin
        @(negedge clk);
        rsp_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  // Give up after a generous fixed time
  initial begin : watchdog
    #(LIMIT_NS);
    $display("** array_insert_delete_search: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [2:0]  cmd;
    logic        start;
    logic [6:0]  pos;
    logic [31:0] val;
    int          r;
    bit          calm;

    clk              = 1'b0;
    rst              = 1'b1;
    stall_request    = 1'b0;
    holds_done       = 0;
    req_ch.valid     = 1'b0;
    req_ch.command   = aids_pkg::CMD_LOAD;
    req_ch.start_new = 1'b0;
    req_ch.position  = 7'd0;
    req_ch.value     = 32'd0;
    sb = new();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty array, bad positions, extremes, duplicates, spare codes
    send_cmd(aids_pkg::CMD_DISPLAY, 1'b0, 7'd0,  32'd0,         pick_gap(1'b0));
    send_cmd(aids_pkg::CMD_DELETE,  1'b0, 7'd1,  32'd0,         pick_gap(1'b0));
    send_cmd(aids_pkg::CMD_SEARCH,  1'b0, 7'd0,  32'd0,         pick_gap(1'b0));
    send_cmd(aids_pkg::CMD_INSERT,  1'b0, 7'd0,  32'd9,         pick_gap(1'b0));
    send_cmd(aids_pkg::CMD_INSERT,  1'b0, 7'd2,  32'd9,         pick_gap(1'b0));
    send_cmd(aids_pkg::CMD_INSERT,  1'b0, 7'd1,  32'h7fff_ffff, pick_gap(1'b0));
    send_cmd(aids_pkg::CMD_LOAD,    1'b1, 7'd0,  32'h8000_0000, pick_gap(1'b0));
    send_cmd(aids_pkg::CMD_LOAD,    1'b0, 7'd0,  32'd0,         pick_gap(1'b0));
    send_cmd(aids_pkg::CMD_LOAD,    1'b0, 7'd0,  32'hffff_ffff, pick_gap(1'b0));
    send_cmd(aids_pkg::CMD_INSERT,  1'b0, 7'd4,  32'd5,         pick_gap(1'b0));
    send_cmd(aids_pkg::CMD_INSERT,  1'b0, 7'd1,  32'h7fff_ffff, pick_gap(1'b0));
    send_cmd(aids_pkg::CMD_INSERT,  1'b0, 7'd7,  32'd3,         pick_gap(1'b0));
    send_cmd(aids_pkg::CMD_LOAD,    1'b0, 7'd0,  32'hffff_ffff, pick_gap(1'b0));
    send_cmd(aids_pkg::CMD_SEARCH,  1'b0, 7'd0,  32'hffff_ffff, pick_gap(1'b0));
    send_cmd(aids_pkg::CMD_SEARCH,  1'b0, 7'd0,  32'd12345,     pick_gap(1'b0));
    send_cmd(aids_pkg::CMD_DELETE,  1'b0, 7'd0,  32'd0,         pick_gap(1'b0));
    send_cmd(aids_pkg::CMD_DELETE,  1'b0, 7'd7,  32'd0,         pick_gap(1'b0));
    send_cmd(aids_pkg::CMD_DELETE,  1'b0, 7'd6,  32'd0,         pick_gap(1'b0));
    send_cmd(aids_pkg::CMD_DELETE,  1'b0, 7'd1,  32'd0,         pick_gap(1'b0));
    send_cmd(aids_pkg::CMD_DISPLAY, 1'b0, 7'd0,  32'd0,         pick_gap(1'b0));
    send_cmd(CMD_SPARE5,            1'b1, 7'd65, 32'hffff_ffff, pick_gap(1'b0));
    send_cmd(CMD_SPARE6,            1'b1, 7'd1,  32'd1,         pick_gap(1'b0));
    send_cmd(CMD_SPARE7,            1'b0, 7'd64, 32'h8000_0000, pick_gap(1'b0));
    send_cmd(aids_pkg::CMD_INSERT,  1'b0, 7'd64, 32'd1,         pick_gap(1'b0));
    send_cmd(aids_pkg::CMD_DELETE,  1'b0, 7'd65, 32'd0,         pick_gap(1'b0));

    // Random: mostly well-formed commands, some noise, one fill to capacity
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i % 40) < 10;
      if (i == HOLD_AT) stall_request = 1'b1;

      if (i == FILL_AT) begin
        send_cmd(aids_pkg::CMD_LOAD, 1'b1, 7'($urandom_range(0, 65)), rand_value(),
                 pick_gap(calm));
        while (sb.fill < CAPACITY) begin
          send_cmd(aids_pkg::CMD_LOAD, 1'b0, 7'($urandom_range(0, 65)), rand_value(),
                   pick_gap(calm));
        end
        send_cmd(aids_pkg::CMD_LOAD,    1'b0, 7'd0,  rand_value(), pick_gap(calm));
        send_cmd(aids_pkg::CMD_INSERT,  1'b0, 7'd65, rand_value(), pick_gap(calm));
        send_cmd(aids_pkg::CMD_INSERT,  1'b0, 7'd1,  rand_value(), pick_gap(calm));
        send_cmd(aids_pkg::CMD_INSERT,  1'b0, 7'd0,  rand_value(), pick_gap(calm));
        send_cmd(aids_pkg::CMD_DISPLAY, 1'b0, 7'd0,  32'd0,        pick_gap(calm));
        send_cmd(aids_pkg::CMD_SEARCH,  1'b0, 7'd0,  sb.stored[CAPACITY - 1],
                 pick_gap(calm));
        send_cmd(aids_pkg::CMD_DELETE,  1'b0, 7'd64, 32'd0,        pick_gap(calm));
        send_cmd(aids_pkg::CMD_DELETE,  1'b0, 7'd1,  32'd0,        pick_gap(calm));
      end

      r     = $urandom_range(0, 99);
      start = 1'b0;
      pos   = 7'($urandom_range(0, 65));
      val   = rand_value();
      if (r < 24) begin
        cmd   = aids_pkg::CMD_LOAD;
        start = ($urandom_range(0, 11) == 0);
      end else if (r < 40) begin
        cmd = aids_pkg::CMD_INSERT;
        pos = ($urandom_range(0, 6) != 0) ? 7'($urandom_range(1, sb.fill + 1))
                                          : odd_position(sb.fill + 1);
      end else if (r < 56) begin
        cmd = aids_pkg::CMD_DELETE;
        pos = (sb.fill > 0 && $urandom_range(0, 6) != 0) ? 7'($urandom_range(1, sb.fill))
                                                          : odd_position(sb.fill);
      end else if (r < 72) begin
        cmd = aids_pkg::CMD_SEARCH;
        if (sb.fill > 0 && $urandom_range(0, 2) != 0)
          val = sb.stored[$urandom_range(0, sb.fill - 1)];
      end else if (r < 84) begin
        cmd = aids_pkg::CMD_DISPLAY;
      end else if (r < 90) begin
        case ($urandom_range(0, 2))
          0:       cmd = CMD_SPARE5;
          1:       cmd = CMD_SPARE6;
          default: cmd = CMD_SPARE7;
        endcase
        start = 1'($urandom_range(0, 1));
      end else begin
        // noise: any code, any flag, any position
        cmd   = 3'($urandom_range(0, 7));
        start = 1'($urandom_range(0, 1));
      end
      send_cmd(cmd, start, pos, val, pick_gap(calm));
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;

    // Drain outstanding beats, then idle a while to catch strays
    while (sb.awaited.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d loads, %0d displays, %0d inserts, %0d deletes, %0d searches, %0d spare",
             sb.cmd_count[aids_pkg::CMD_LOAD], sb.cmd_count[aids_pkg::CMD_DISPLAY],
             sb.cmd_count[aids_pkg::CMD_INSERT], sb.cmd_count[aids_pkg::CMD_DELETE],
             sb.cmd_count[aids_pkg::CMD_SEARCH],
             sb.cmd_count[CMD_SPARE5] + sb.cmd_count[CMD_SPARE6] + sb.cmd_count[CMD_SPARE7]);
    $display("checked %0d response beats, deepest array %0d, long hold-offs %0d, mismatches %0d",
             sb.beats_checked, sb.deepest, holds_done, sb.errors);
    if (sb.errors == 0) begin
      $display("** array_insert_delete_search: PASSED **");
    end else begin
      $display("** array_insert_delete_search: FAILED **");
    end
    $finish;
  end

endmodule
